// ----- src/stack_bytecode_interpreter_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the stack bytecode interpreter
// Shared property wrappers used by the top level.
// ----------------------------------------------------------------------------
`ifndef STACK_BYTECODE_INTERPRETER_MACROS_SVH
`define STACK_BYTECODE_INTERPRETER_MACROS_SVH

// Implication checked on the next edge after the antecedent.
`define SBI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Implication checked in the same cycle.
`define SBI_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// ----- src/sbi_pkg.sv -----
// ----------------------------------------------------------------------------
// sbi_pkg
// Shared constants, opcodes and types of the stack bytecode interpreter.
// ----------------------------------------------------------------------------
package sbi_pkg;

  localparam int MEM_DEPTH = 65536;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);

  localparam logic [15:0] RST_START_PC = 16'h0140;
  localparam logic [15:0] RST_START_SP = 16'hFEFB;
  localparam logic [15:0] RST_HOST_LO  = 16'hC104;
  localparam logic [15:0] RST_HOST_HI  = 16'hC18C;

  // commands
  localparam logic [2:0] CMD_WRITE   = 3'd0;
  localparam logic [2:0] CMD_READ    = 3'd1;
  localparam logic [2:0] CMD_STEP    = 3'd2;
  localparam logic [2:0] CMD_RESUME  = 3'd3;
  localparam logic [2:0] CMD_RESTART = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_START_PC = 2'd0;
  localparam logic [1:0] CFG_START_SP = 2'd1;
  localparam logic [1:0] CFG_HOST_LO  = 2'd2;
  localparam logic [1:0] CFG_HOST_HI  = 2'd3;

  // status codes
  localparam logic [1:0] ST_READY = 2'd0;
  localparam logic [1:0] ST_HOST  = 2'd1;
  localparam logic [1:0] ST_ASMC  = 2'd2;
  localparam logic [1:0] ST_BADOP = 2'd3;

  // opcode numbers (opcode byte >> 1)
  localparam logic [6:0] OP_LD1IM = 7'd0,  OP_LD1SOFF = 7'd1, OP_LD1 = 7'd2;
  localparam logic [6:0] OP_LDB1 = 7'd3,   OP_LD1R = 7'd4,    OP_LDB1R = 7'd5;
  localparam logic [6:0] OP_ST1 = 7'd6,    OP_STB1 = 7'd7,    OP_ST1SP = 7'd8;
  localparam logic [6:0] OP_STB1SP = 7'd9, OP_PUSHR1 = 7'd10, OP_EXG1 = 7'd11;
  localparam logic [6:0] OP_JMPL = 7'd12,  OP_BRZL = 7'd13,   OP_JSRL = 7'd14;
  localparam logic [6:0] OP_JSRSP = 7'd15, OP_RTSC = 7'd16,   OP_MODSP = 7'd17;
  localparam logic [6:0] OP_DBL1 = 7'd18,  OP_ADDS = 7'd19,   OP_SUBFST = 7'd20;
  localparam logic [6:0] OP_MUL1 = 7'd21,  OP_DIV1 = 7'd22,   OP_MOD = 7'd23;
  localparam logic [6:0] OP_ORS = 7'd24,   OP_XORS = 7'd25,   OP_ANDS = 7'd26;
  localparam logic [6:0] OP_ASRS = 7'd27,  OP_ASLS = 7'd28,   OP_NEGR = 7'd29;
  localparam logic [6:0] OP_NOTR = 7'd30,  OP_INCR = 7'd31,   OP_DECR = 7'd32;
  localparam logic [6:0] OP_ZEQ = 7'd33,   OP_ZNE = 7'd34,    OP_ZLT = 7'd35;
  localparam logic [6:0] OP_ZLE = 7'd36,   OP_ZGT = 7'd37,    OP_ZGE = 7'd38;
  localparam logic [6:0] OP_ULT = 7'd39,   OP_ULE = 7'd40,    OP_UGT = 7'd41;
  localparam logic [6:0] OP_UGE = 7'd42,   OP_ASMC = 7'd43;

  // divider request / response
  typedef struct packed {
    logic        start;
    logic [15:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] quotient;
    logic [15:0] remainder;
  } div_rsp_t;

endpackage

// ----- src/sbi_ram.sv -----
// ----------------------------------------------------------------------------
// sbi_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module sbi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write or read one entry per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- src/sbi_div.sv -----
// ----------------------------------------------------------------------------
// sbi_div
// 16-bit unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sbi_div (
  input  logic             clk,
  input  logic             rst,
  input  sbi_pkg::div_req_t req,
  output sbi_pkg::div_rsp_t rsp
);

  logic [15:0] quo;
  logic [15:0] rem;
  logic [15:0] dvs;
  logic [4:0]  cnt;
  logic        busy;
  logic        done;
  logic [16:0] trial;

  assign trial = {rem, quo[15]} - {1'b0, dvs};

  // shift in one dividend bit and subtract when it fits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        quo  <= req.dividend;
        rem  <= '0;
        dvs  <= req.divisor;
        cnt  <= 5'd16;
      end else if (busy) begin
        if (!trial[16]) begin
          rem <= trial[15:0];
          quo <= {quo[14:0], 1'b1};
        end else begin
          rem <= {rem[14:0], quo[15]};
          quo <= {quo[14:0], 1'b0};
        end
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp = {done, quo, rem};

endmodule

// ----- src/stack_bytecode_interpreter.sv -----
// ----------------------------------------------------------------------------
// stack_bytecode_interpreter
// One-accumulator stack machine over a byte memory, driven by commands.
// ----------------------------------------------------------------------------
// m_tvalid rises from S_DONE once the accepted command is through: restart
// and an ignored command go there from decode, a byte write through S_WR, a
// byte read and a resume through S_RD, S_RD_WAIT and S_EXEC. A step decodes,
// reads each byte (S_RD, S_RD_WAIT), writes each byte (S_WR), runs each
// execute phase (S_EXEC) and then presents the result in S_DONE. All accesses
// go one byte at a time through the single-port byte memory; divide and
// modulo also wait in S_DIV for the serial divider. A new command is accepted
// the cycle after the previous result has been taken.
module stack_bytecode_interpreter (
  input  logic        clk,
  input  logic        rst,
  // s_tdata: command[2:0], address[18:3], byte_in[26:19], call_result[42:27]
  input  logic [47:0] s_tdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // m_tdata: status[1:0], program_counter[17:2], stack_pointer[33:18],
  //          accumulator[49:34], read_byte[57:50]
  output logic [63:0] m_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  `include "stack_bytecode_interpreter_macros.svh"

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_RD, S_RD_WAIT, S_WR, S_EXEC, S_DIV, S_DONE
  } state_t;

  // micro phases of an instruction
  typedef enum logic [2:0] {
    P_OPC, P_OPND, P_POP, P_DATA, P_STORE, P_FIN
  } phase_t;

  state_t      state;
  phase_t      phase;
  logic [15:0] start_pc, start_sp, host_lo, host_hi;
  logic [15:0] pc, sp, acc;
  logic [1:0]  run_status;
  logic [2:0]  cmd;
  logic [15:0] cmd_addr, cmd_res;
  logic [7:0]  cmd_byte, rd_byte;
  logic [6:0]  opn;
  logic [15:0] popw, dword;
  logic [15:0] wr_val;
  logic [15:0] wr_addr;
  logic        wr_word, wr_hi_done;
  logic [15:0] rd_addr;
  logic        rd_word, rd_hi_done;
  logic [7:0]  rd_hi;

  logic                       mem_we;
  logic [sbi_pkg::MEM_AW-1:0] mem_addr;
  logic [7:0]                 mem_wdata, mem_rdata;
  logic [15:0]                mem_addr16;

  sbi_pkg::div_req_t div_req;
  sbi_pkg::div_rsp_t div_rsp;

  sbi_ram #(.WIDTH(8), .DEPTH(sbi_pkg::MEM_DEPTH)) u_ram (
    .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(mem_wdata), .rdata(mem_rdata)
  );

  sbi_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  assign mem_addr = mem_addr16[sbi_pkg::MEM_AW-1:0];
  assign s_tready = (state == S_IDLE) && !m_tvalid;

  // memory port: reads in S_RD, writes in S_WR
  always_comb begin
    mem_we     = 1'b0;
    mem_wdata  = 8'h00;
    mem_addr16 = rd_addr;
    if (state == S_WR) begin
      mem_we     = 1'b1;
      mem_addr16 = wr_addr;
      mem_wdata  = (wr_word && !wr_hi_done) ? wr_val[15:8] : wr_val[7:0];
    end
  end

  // binary operation on popped word and accumulator
  logic [15:0] bin_res;
  logic [31:0] prod;
  assign prod = popw * acc;
  always_comb begin
    case (opn)
      sbi_pkg::OP_ADDS:   bin_res = popw + acc;
      sbi_pkg::OP_SUBFST: bin_res = popw - acc;
      sbi_pkg::OP_MUL1:   bin_res = prod[15:0];
      sbi_pkg::OP_ORS:    bin_res = popw | acc;
      sbi_pkg::OP_XORS:   bin_res = popw ^ acc;
      sbi_pkg::OP_ANDS:   bin_res = popw & acc;
      sbi_pkg::OP_ASRS:   bin_res = (acc >= 16'd16) ? 16'h0 : (popw >> acc[3:0]);
      sbi_pkg::OP_ASLS:   bin_res = (acc >= 16'd16) ? 16'h0 : (popw << acc[3:0]);
      sbi_pkg::OP_ZEQ:    bin_res = {15'h0, popw == acc};
      sbi_pkg::OP_ZNE:    bin_res = {15'h0, popw != acc};
      sbi_pkg::OP_ZLT:    bin_res = {15'h0, $signed(popw) <  $signed(acc)};
      sbi_pkg::OP_ZLE:    bin_res = {15'h0, $signed(popw) <= $signed(acc)};
      sbi_pkg::OP_ZGT:    bin_res = {15'h0, $signed(popw) >  $signed(acc)};
      sbi_pkg::OP_ZGE:    bin_res = {15'h0, $signed(popw) >= $signed(acc)};
      sbi_pkg::OP_ULT:    bin_res = {15'h0, popw <  acc};
      sbi_pkg::OP_ULE:    bin_res = {15'h0, popw <= acc};
      sbi_pkg::OP_UGT:    bin_res = {15'h0, popw >  acc};
      default:            bin_res = {15'h0, popw >= acc};
    endcase
  end

  logic host_hit;
  assign host_hit = (host_lo <= host_hi) && (dword >= host_lo) && (dword <= host_hi);

  logic [15:0] rd_result;
  assign rd_result = rd_word ? {rd_hi, mem_rdata} : {8'h00, mem_rdata};

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      start_pc <= sbi_pkg::RST_START_PC;
      start_sp <= sbi_pkg::RST_START_SP;
      host_lo  <= sbi_pkg::RST_HOST_LO;
      host_hi  <= sbi_pkg::RST_HOST_HI;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sbi_pkg::CFG_START_PC: start_pc <= cfg_data;
        sbi_pkg::CFG_START_SP: start_sp <= cfg_data;
        sbi_pkg::CFG_HOST_LO:  host_lo  <= cfg_data;
        default:               host_hi  <= cfg_data;
      endcase
    end
  end

  // command sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      phase      <= P_OPC;
      pc         <= sbi_pkg::RST_START_PC;
      sp         <= sbi_pkg::RST_START_SP;
      acc        <= '0;
      run_status <= sbi_pkg::ST_READY;
      m_tvalid   <= 1'b0;
      div_req    <= '0;
    end else begin
      div_req.start <= 1'b0;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            cmd      <= s_tdata[2:0];
            cmd_addr <= s_tdata[18:3];
            cmd_byte <= s_tdata[26:19];
            cmd_res  <= s_tdata[42:27];
            rd_byte  <= 8'h00;
            state    <= S_DECODE;
          end
        end
        S_DECODE: begin
          state <= S_DONE;
          unique case (cmd)
            sbi_pkg::CMD_WRITE: begin
              wr_addr <= cmd_addr; wr_val <= {8'h00, cmd_byte};
              wr_word <= 1'b0; wr_hi_done <= 1'b0; state <= S_WR;
            end
            sbi_pkg::CMD_READ: begin
              rd_addr <= cmd_addr; rd_word <= 1'b0; rd_hi_done <= 1'b0;
              state <= S_RD;
            end
            sbi_pkg::CMD_STEP: begin
              if (run_status == sbi_pkg::ST_READY) begin
                phase <= P_OPC; rd_addr <= pc; rd_word <= 1'b0;
                rd_hi_done <= 1'b0; state <= S_RD;
              end
            end
            sbi_pkg::CMD_RESUME: begin
              if (run_status == sbi_pkg::ST_HOST) begin
                acc <= cmd_res; run_status <= sbi_pkg::ST_READY;
                phase <= P_FIN; opn <= sbi_pkg::OP_RTSC;
                rd_addr <= sp + 16'd1; rd_word <= 1'b1; rd_hi_done <= 1'b0;
                sp <= sp + 16'd2; state <= S_RD;
              end
            end
            sbi_pkg::CMD_RESTART: begin
              pc <= start_pc; sp <= start_sp; acc <= '0;
              run_status <= sbi_pkg::ST_READY;
            end
            default: ;
          endcase
        end
        S_RD: state <= S_RD_WAIT;
        S_RD_WAIT: begin
          if (rd_word && !rd_hi_done) begin
            rd_hi <= mem_rdata; rd_hi_done <= 1'b1;
            rd_addr <= rd_addr + 16'd1; state <= S_RD;
          end else begin
            dword <= rd_result;
            state <= S_EXEC;
          end
        end
        S_WR: begin
          if (wr_word && !wr_hi_done) begin
            wr_hi_done <= 1'b1; wr_addr <= wr_addr + 16'd1;
          end else if (cmd == sbi_pkg::CMD_STEP && phase == P_STORE) begin
            state <= S_EXEC;
          end else begin
            state <= S_DONE;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            if (opn == sbi_pkg::OP_DIV1) begin
              acc <= (acc == 16'h0) ? 16'hFFFF : div_rsp.quotient;
            end else begin
              acc <= (acc == 16'h0) ? popw : div_rsp.remainder;
            end
            state <= S_DONE;
          end
        end
        S_EXEC: begin
          state <= S_DONE;
          if (cmd == sbi_pkg::CMD_READ) begin
            rd_byte <= dword[7:0];
          end else if (cmd == sbi_pkg::CMD_RESUME) begin
            pc <= dword;
          end else begin
            unique case (phase)
              P_OPC: begin
                pc  <= pc + 16'd1;
                opn <= dword[7:1];
                rd_word <= 1'b1; rd_hi_done <= 1'b0;
                if (dword[0] || dword[7:1] > sbi_pkg::OP_ASMC) begin
                  run_status <= sbi_pkg::ST_BADOP;
                end else begin
                  unique case (dword[7:1])
                    sbi_pkg::OP_LD1IM, sbi_pkg::OP_LD1SOFF, sbi_pkg::OP_LD1,
                    sbi_pkg::OP_LDB1, sbi_pkg::OP_ST1, sbi_pkg::OP_STB1,
                    sbi_pkg::OP_JMPL, sbi_pkg::OP_MODSP: begin
                      rd_addr <= pc + 16'd1; phase <= P_OPND; state <= S_RD;
                    end
                    sbi_pkg::OP_BRZL: begin
                      if (acc == 16'h0) begin
                        rd_addr <= pc + 16'd1; phase <= P_OPND; state <= S_RD;
                      end else begin
                        pc <= pc + 16'd3;
                      end
                    end
                    sbi_pkg::OP_JSRL: begin
                      wr_addr <= sp - 16'd1; wr_val <= pc + 16'd3;
                      wr_word <= 1'b1; wr_hi_done <= 1'b0;
                      sp <= sp - 16'd2; phase <= P_STORE; state <= S_WR;
                    end
                    sbi_pkg::OP_PUSHR1: begin
                      wr_addr <= sp - 16'd1; wr_val <= acc;
                      wr_word <= 1'b1; wr_hi_done <= 1'b0;
                      sp <= sp - 16'd2; phase <= P_FIN; state <= S_WR;
                    end
                    sbi_pkg::OP_LD1R, sbi_pkg::OP_LDB1R: begin
                      rd_addr <= acc; rd_word <= (dword[7:1] == sbi_pkg::OP_LD1R);
                      phase <= P_DATA; state <= S_RD;
                    end
                    sbi_pkg::OP_DBL1: acc <= {acc[14:0], 1'b0};
                    sbi_pkg::OP_NEGR: acc <= 16'h0 - acc;
                    sbi_pkg::OP_NOTR: acc <= ~acc;
                    sbi_pkg::OP_INCR: acc <= acc + 16'd1;
                    sbi_pkg::OP_DECR: acc <= acc - 16'd1;
                    sbi_pkg::OP_ASMC: run_status <= sbi_pkg::ST_ASMC;
                    default: begin
                      // stack-top read: pops, exchange, call via stack, return
                      rd_addr <= sp + 16'd1; phase <= P_POP; state <= S_RD;
                    end
                  endcase
                end
              end
              P_OPND: begin
                pc   <= pc + 16'd2;
                unique case (opn)
                  sbi_pkg::OP_LD1IM:   acc <= dword;
                  sbi_pkg::OP_LD1SOFF: acc <= dword + sp + 16'd1;
                  sbi_pkg::OP_MODSP:   sp  <= sp + dword;
                  sbi_pkg::OP_JMPL, sbi_pkg::OP_BRZL: pc <= dword;
                  sbi_pkg::OP_LD1, sbi_pkg::OP_LDB1: begin
                    rd_addr <= dword; rd_word <= (opn == sbi_pkg::OP_LD1);
                    rd_hi_done <= 1'b0; phase <= P_DATA; state <= S_RD;
                  end
                  default: begin
                    // ST1 / STB1
                    wr_addr <= dword; wr_val <= acc;
                    wr_word <= (opn == sbi_pkg::OP_ST1); wr_hi_done <= 1'b0;
                    phase <= P_FIN; state <= S_WR;
                  end
                endcase
              end
              P_DATA: begin
                acc <= rd_word ? dword : {{8{dword[7]}}, dword[7:0]};
              end
              P_STORE: begin
                // JSRL: return address pushed, now fetch target after opcode
                if (rd_hi_done) begin
                  pc <= dword;
                  if (host_hit) run_status <= sbi_pkg::ST_HOST;
                end else begin
                  rd_addr <= pc; rd_word <= 1'b1; rd_hi_done <= 1'b0;
                  state <= S_RD;
                end
              end
              P_POP: begin
                popw <= dword;
                unique case (opn)
                  sbi_pkg::OP_ST1SP, sbi_pkg::OP_STB1SP: begin
                    sp <= sp + 16'd2; wr_addr <= dword; wr_val <= acc;
                    wr_word <= (opn == sbi_pkg::OP_ST1SP); wr_hi_done <= 1'b0;
                    phase <= P_FIN; state <= S_WR;
                  end
                  sbi_pkg::OP_EXG1: begin
                    acc <= dword; wr_addr <= sp + 16'd1; wr_val <= acc;
                    wr_word <= 1'b1; wr_hi_done <= 1'b0;
                    phase <= P_FIN; state <= S_WR;
                  end
                  sbi_pkg::OP_JSRSP: begin
                    pc <= dword; wr_addr <= sp + 16'd1; wr_val <= pc;
                    wr_word <= 1'b1; wr_hi_done <= 1'b0;
                    if ((host_lo <= host_hi) && (dword >= host_lo) && (dword <= host_hi))
                      run_status <= sbi_pkg::ST_HOST;
                    phase <= P_FIN; state <= S_WR;
                  end
                  sbi_pkg::OP_RTSC: begin
                    pc <= dword; sp <= sp + 16'd2;
                  end
                  sbi_pkg::OP_DIV1, sbi_pkg::OP_MOD: begin
                    sp <= sp + 16'd2;
                    div_req.start <= 1'b1; div_req.dividend <= dword;
                    div_req.divisor <= acc; state <= S_DIV;
                  end
                  default: begin
                    sp <= sp + 16'd2; phase <= P_FIN; state <= S_EXEC;
                  end
                endcase
              end
              default: begin
                // P_FIN: binary op result once popw is registered
                if (opn >= sbi_pkg::OP_ADDS && opn != sbi_pkg::OP_JSRSP &&
                    opn != sbi_pkg::OP_EXG1 && opn != sbi_pkg::OP_ST1SP &&
                    opn != sbi_pkg::OP_STB1SP && opn != sbi_pkg::OP_RTSC &&
                    opn != sbi_pkg::OP_PUSHR1) begin
                  acc <= bin_res;
                end
              end
            endcase
          end
        end
        default: begin
          // S_DONE: present result
          m_tvalid <= 1'b1;
          state    <= S_IDLE;
        end
      endcase
    end
  end

  // JSRL store returns to EXEC with rd_hi_done clear; mark the target read
  // by reusing rd_hi_done, which the word read sets before S_EXEC.

  assign m_tdata = {6'h0, rd_byte, acc, sp, pc, run_status};

  `SBI_ASSERT_SAME(a_out_idle, m_tvalid, state == S_IDLE)
  `SBI_ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready, state == S_DECODE)
  `SBI_ASSERT_SAME(a_no_accept_busy, m_tvalid, !s_tready)

endmodule
